// File: sv/sab_pkg.sv
// ----------------------------------------------------------------------------
// sab_pkg: shared types and constants
// Stage counts and sideband structs for the sphere/box penetration pipeline.
// ----------------------------------------------------------------------------
package sab_pkg;

	localparam int SQRT_STAGES = 32;   // one root bit per stage
	localparam int DIV_STAGES  = 31;   // one quotient bit per stage

	// geometry sideband carried alongside the square root
	typedef struct packed {
		logic [2:0]       neg;
		logic [2:0][30:0] mag;
		logic [30:0]      radius;
		logic             hit;
		logic             zero;
	} geo_t;

	// sideband carried alongside the dividers
	typedef struct packed {
		logic [2:0] neg;
		logic       hit;
		logic       push;
	} post_t;

endpackage

// File: sv/sphere_aabb_penetration_core.sv
// ----------------------------------------------------------------------------
// sphere_aabb_penetration_core: sphere versus axis-aligned box test
// Clamp, squared distance, pipelined square root and division; one result
// per input transaction with a Q16.16 push-out vector.
// ----------------------------------------------------------------------------
//  channel  | dir | fields
//  s_axis   | in  | center xyz, sphere_radius, box_min xyz, box_max xyz
//  m_axis   | out | hit, push xyz
//
//  Pipeline: 3 front stages, 32 square-root stages, 1 multiply
//  stage, 31 divider stages, 1 output register.
//  One transaction per cycle while m_axis is not stalled; the whole pipe advances together.
//  A stall on m_axis freezes every stage and drops s_tready.
//  Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module sphere_aabb_penetration_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// center_x, center_y, center_z, sphere_radius[30:0], box_min_x, box_min_y,
	// box_min_z, box_max_x, box_max_y, box_max_z, zero pad
	input  logic [319:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// hit, push_x, push_y, push_z, zero pad
	output logic [103:0] m_tdata
);
	import sab_pkg::*;

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// ---- stage 1: clamp and per-axis offset
	logic signed [31:0] cen [3];
	logic signed [31:0] bmn [3];
	logic signed [31:0] bmx [3];
	logic [30:0]        rad_in;

	assign cen[0] = s_tdata[31:0];
	assign cen[1] = s_tdata[63:32];
	assign cen[2] = s_tdata[95:64];
	assign rad_in = s_tdata[126:96];
	assign bmn[0] = s_tdata[158:127];
	assign bmn[1] = s_tdata[190:159];
	assign bmn[2] = s_tdata[222:191];
	assign bmx[0] = s_tdata[254:223];
	assign bmx[1] = s_tdata[286:255];
	assign bmx[2] = s_tdata[318:287];

	logic             vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0][30:0] mag_s1;
	logic [2:0]       neg_s1;
	logic             far_s1;
	logic [30:0]      rad_s1;

	logic [2:0][30:0] mag_c;
	logic [2:0]       neg_c;
	logic [2:0]       far_c;

	always_comb begin
		logic signed [31:0] t;
		logic signed [31:0] cl;
		logic signed [32:0] d;
		logic        [32:0] m;
		for (int i = 0; i < 3; i++) begin
			t  = (cen[i] > bmn[i]) ? cen[i] : bmn[i];
			cl = (t < bmx[i]) ? t : bmx[i];
			d  = 33'(cen[i]) - 33'(cl);
			m  = d[32] ? 33'(-d) : 33'(d);
			mag_c[i] = m[30:0];
			neg_c[i] = d[32];
			far_c[i] = |m[32:31];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_c;
			neg_s1 <= neg_c;
			far_s1 <= |far_c;
			rad_s1 <= rad_in;
		end
	end

	// ---- stage 2: squares
	logic [2:0][61:0] sq_s2;
	logic [61:0]      r2_s2;
	logic [2:0][30:0] mag_s2;
	logic [2:0]       neg_s2;
	logic             far_s2;
	logic [30:0]      rad_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i] <= 62'(mag_s1[i]) * 62'(mag_s1[i]);
			end
			r2_s2  <= 62'(rad_s1) * 62'(rad_s1);
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			far_s2 <= far_s1;
			rad_s2 <= rad_s1;
		end
	end

	// ---- stage 3: sum and compare
	logic [63:0] dist2_c;
	logic [63:0] dist2_s3;
	geo_t        geo_s3;

	assign dist2_c = 64'(sq_s2[0]) + 64'(sq_s2[1]) + 64'(sq_s2[2]);

	always_ff @(posedge clk) begin
		if (en) begin
			dist2_s3       <= dist2_c;
			geo_s3.neg     <= neg_s2;
			geo_s3.mag     <= mag_s2;
			geo_s3.radius  <= rad_s2;
			geo_s3.hit     <= !far_s2 && (dist2_c < 64'(r2_s2));
			geo_s3.zero    <= dist2_c == '0;
		end
	end

	// ---- square root
	logic        sq_valid;
	logic [31:0] root;
	geo_t        geo_sq;

	sab_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s3),
		.in_x      (dist2_s3),
		.in_side   (geo_s3),
		.out_valid (sq_valid),
		.out_root  (root),
		.out_side  (geo_sq)
	);

	// ---- stage 4: penetration depth times offset
	logic [31:0]      pen_c;
	logic [2:0][61:0] prod_s4;
	logic [31:0]      root_s4;
	post_t            post_s4;

	assign pen_c = 32'(geo_sq.radius) - root;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s4[i] <= 62'(geo_sq.mag[i]) * 62'(pen_c[30:0]);
			end
			root_s4       <= root;
			post_s4.neg   <= geo_sq.neg;
			post_s4.hit   <= geo_sq.hit;
			post_s4.push  <= geo_sq.hit && !geo_sq.zero;
		end
	end

	// ---- dividers, one per axis
	logic [2:0][30:0] quo;

	for (genvar a = 0; a < 3; a++) begin : g_div
		sab_div u_div (
			.clk (clk),
			.en  (en),
			.num (prod_s4[a]),
			.den (root_s4),
			.quo (quo[a])
		);
	end

	logic [DIV_STAGES-1:0] vld_d;
	post_t                 post_d [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			post_d[0] <= post_s4;
			for (int k = 1; k < DIV_STAGES; k++) begin
				post_d[k] <= post_d[k-1];
			end
		end
	end

	// ---- output register
	post_t            post_o;
	logic [2:0][31:0] push_c;
	logic [103:0]     tdata_q;
	logic             tvalid_q;

	assign post_o = post_d[DIV_STAGES-1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (!post_o.push) begin
				push_c[i] = '0;
			end else if (post_o.neg[i]) begin
				push_c[i] = -{1'b0, quo[i]};
			end else begin
				push_c[i] = {1'b0, quo[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tdata_q <= {7'd0, push_c[2], push_c[1], push_c[0], post_o.hit};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
			vld_d    <= '0;
			tvalid_q <= 1'b0;
		end else if (en) begin
			vld_s1   <= s_tvalid;
			vld_s2   <= vld_s1;
			vld_s3   <= vld_s2;
			vld_s4   <= sq_valid;
			vld_d    <= {vld_d[DIV_STAGES-2:0], vld_s4};
			tvalid_q <= vld_d[DIV_STAGES-1];
		end
	end

	assign m_tvalid = tvalid_q;
	assign m_tdata  = tdata_q;

endmodule

// File: sv/sab_isqrt.sv
// ----------------------------------------------------------------------------
// sab_isqrt: pipelined integer square root
// floor(sqrt(x)) of a 64-bit value, one result bit per register stage.
// ----------------------------------------------------------------------------
module sab_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [63:0]       in_x,
	input  sab_pkg::geo_t     in_side,
	output logic              out_valid,
	output logic [31:0]       out_root,
	output sab_pkg::geo_t     out_side
);
	import sab_pkg::*;

	logic [SQRT_STAGES-1:0] vld_s;
	logic [63:0]            rem_s  [SQRT_STAGES];
	logic [63:0]            root_s [SQRT_STAGES];
	geo_t                   side_s [SQRT_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[SQRT_STAGES-2:0], in_valid};
		end
	end

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
		logic [63:0] rem_in;
		logic [63:0] root_in;
		geo_t        side_in;
		logic [63:0] trial;
		logic        take;

		if (j == 0) begin : g_first
			assign rem_in  = in_x;
			assign root_in = '0;
			assign side_in = in_side;
		end else begin : g_next
			assign rem_in  = rem_s[j-1];
			assign root_in = root_s[j-1];
			assign side_in = side_s[j-1];
		end

		assign trial = root_in + BIT;
		assign take  = rem_in >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j]  <= take ? rem_in - trial : rem_in;
				root_s[j] <= take ? (root_in >> 1) + BIT : root_in >> 1;
				side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[SQRT_STAGES-1];
	assign out_root  = root_s[SQRT_STAGES-1][31:0];
	assign out_side  = side_s[SQRT_STAGES-1];

endmodule

// File: sv/sab_div.sv
// ----------------------------------------------------------------------------
// sab_div: pipelined restoring divider
// 62-bit numerator by 32-bit divisor, quotient known to fit in 31 bits.
// ----------------------------------------------------------------------------
module sab_div (
	input  logic        clk,
	input  logic        en,
	input  logic [61:0] num,
	input  logic [31:0] den,
	output logic [30:0] quo
);
	import sab_pkg::*;

	logic [31:0] rem_s [DIV_STAGES];
	logic [30:0] low_s [DIV_STAGES];
	logic [31:0] den_s [DIV_STAGES];
	logic [30:0] quo_s [DIV_STAGES];

	for (genvar i = 0; i < DIV_STAGES; i++) begin : g_stage
		logic [31:0] rem_in;
		logic [30:0] low_in;
		logic [31:0] den_in;
		logic [30:0] quo_in;
		logic [32:0] cand;
		logic        take;

		if (i == 0) begin : g_first
			// upper numerator bits are already below the divisor
			assign rem_in = {1'b0, num[61:31]};
			assign low_in = num[30:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign low_in = low_s[i-1];
			assign den_in = den_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign cand = {rem_in, low_in[30]};
		assign take = cand >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? 32'(cand - {1'b0, den_in}) : cand[31:0];
				low_s[i] <= {low_in[29:0], 1'b0};
				den_s[i] <= den_in;
				quo_s[i] <= {quo_in[29:0], take};
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

// File: sv/sab_checker.sv
// ----------------------------------------------------------------------------
// sab_checker: port-level assertions
// Watches the streaming ports of the penetration core over time.
// ----------------------------------------------------------------------------
module sab_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [103:0] m_tdata
);

	// an empty output register never blocks the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("input stalled with empty output");

	// a stalled output freezes the whole pipe
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready) else $error("input taken under stall");

	// no hit means a zero push vector, and pad bits are zero
	a_zero_push: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[96:1] == '0))
		else $error("push without hit");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[103:97] == '0)) else $error("pad bits set");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed under stall");

endmodule

bind sphere_aabb_penetration_core sab_checker u_sab_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
